// File: rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg: shared constants of the strong connectivity check unit
// Default graph capacities and the fixed widths of the item fields.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int SCC_MAX_NODES = 1024;
  localparam int SCC_MAX_EDGES = 4096;

  // Fixed field widths of the item and configuration ports.
  localparam int NODE_FIELD_W = 11;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 24;

endpackage

// File: rtl/scc_ram.sv
// ----------------------------------------------------------------------------
// scc_ram: simple dual-port synchronous memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/strong_connectivity_check_unit.sv
// ----------------------------------------------------------------------------
// strong_connectivity_check_unit: Kosaraju-style strong connectivity check
// Loads directed edges into linked adjacency lists and, on a finish item,
// walks the graph depth first to decide whether it is strongly connected.
// ----------------------------------------------------------------------------
// For each edge item the list heads of both endpoints are read in
// the accept cycle and the new edge is linked in the next one. A dropped edge is
// only flagged and the unit stays ready. A finish item walks the graph with one
// shared depth-first engine whose stack and visited marks live in synchronous
// memories. A walk visits every node it reaches and every edge it follows; the
// first and second passes also scan the nodes, and a sweep over the n effective
// nodes clears the visited marks before each pass; the third pass runs only
// when the second finds an unreached node. The result is held in an output
// register, so it may wait for the consumer while the unit goes on. After
// reset, and again after each result is registered, a clearing pass over all
// MAX_NODES list heads empties all adjacency lists; no input item is
// accepted during it, but configuration writes are taken at any time.
module strong_connectivity_check_unit
  import scc_pkg::*;
#(
  parameter int MAX_NODES = SCC_MAX_NODES,
  parameter int MAX_EDGES = SCC_MAX_EDGES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration: node_count.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [NODE_FIELD_W-1:0] cfg_data,
  // Input items.
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DATA_W-1:0]    in_tdata,   // [10:0] edge_from, [21:11] edge_to
  input  logic                    in_tuser,   // [0] req_type
  // Result items.
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata   // [0] strongly_connected,
                                              // [11:1] route_from, [22:12] route_to,
                                              // [23] edge_overflow
);

  localparam int NA = $clog2(MAX_NODES);
  localparam int NW = NA + 1;
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EB = $clog2(MAX_EDGES + 1);
  localparam int CW = (NW > NODE_FIELD_W) ? NW : NODE_FIELD_W + 1;
  localparam logic [EB-1:0] LIST_END = EB'(MAX_EDGES);

  localparam logic [4:0] S_CLRH = 5'd0,  S_IDLE = 5'd1,  S_LOAD = 5'd2,
                         S_CLRV = 5'd3,  S_P1RD = 5'd4,  S_P1CK = 5'd5,
                         S_P1NX = 5'd6,  S_SCAN = 5'd7,  S_SCK  = 5'd8,
                         S_P3RD = 5'd9,  S_P3CK = 5'd10, S_OUT  = 5'd11,
                         S_WS   = 5'd12, S_WSC  = 5'd13, S_WH   = 5'd14,
                         S_WE   = 5'd15, S_WN   = 5'd16, S_WV   = 5'd17,
                         S_WP   = 5'd18;

  localparam logic [1:0] P_FIRST = 2'd0, P_REV = 2'd1, P_BACK = 2'd2;

  logic [4:0]              st_r, st_nxt;
  logic [1:0]              ph_r, ph_nxt;
  logic [NODE_FIELD_W-1:0] ncfg_r;
  logic [NW-1:0]           n_eff;
  logic [NW-1:0]           cnt_r, cnt_nxt;
  logic [NW-1:0]           u_r, u_nxt;
  logic [NW-1:0]           sp_r, sp_nxt;
  logic [EB-1:0]           top_r, top_nxt;
  logic [EB-1:0]           total_r, total_nxt;
  logic                    drop_r, drop_nxt;
  logic                    dir_r, dir_nxt;
  logic [NA-1:0]           s_r, s_nxt, v_r, v_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [NA-1:0]           root_r, root_nxt, miss_r, miss_nxt;
  logic                    rsc_r, rsc_nxt;
  logic [NODE_FIELD_W-1:0] rfrom_r, rfrom_nxt, rto_r, rto_nxt;
  logic                    ov_r;
  logic [OUT_DATA_W-1:0]   od_r;
  logic [4:0]              done_st;

  // Memory ports.
  logic          fh_we, rh_we, ed_we, vis_we, stk_we;
  logic [NA-1:0] fh_wa, rh_wa, fh_ra, rh_ra, vis_wa, vis_ra, stk_wa, stk_ra;
  logic [EB-1:0] fh_wd, rh_wd, fh_rd, rh_rd, fn_rd, rn_rd, stk_wd, stk_rd;
  logic [NA-1:0] src_rd, dst_rd;
  logic          vis_wd, vis_rd;

  // Input decode.
  logic [CW-1:0] in_a, in_b, in_am1, in_bm1, n_x;
  logic          bad_edge, in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (ncfg_r == '0) begin
      n_eff = NW'(1);
    end else if (CW'(ncfg_r) > CW'(MAX_NODES)) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(CW'(ncfg_r));
    end
  end

  assign n_x    = CW'(n_eff);
  assign in_a   = CW'(in_tdata[10:0]);
  assign in_b   = CW'(in_tdata[21:11]);
  assign in_am1 = in_a - CW'(1);
  assign in_bm1 = in_b - CW'(1);
  assign bad_edge = (in_a == '0) || (in_a > n_x) || (in_b == '0) || (in_b > n_x) ||
                    (total_r >= EB'(MAX_EDGES));

  // Where a finished walk hands control back to.
  always_comb begin
    unique case (ph_r)
      P_FIRST: done_st = S_P1NX;
      P_REV:   done_st = S_SCAN;
      default: done_st = S_P3RD;
    endcase
  end

  // Memory address and write control.
  always_comb begin
    fh_we  = 1'b0;
    rh_we  = 1'b0;
    fh_wa  = a_r;
    rh_wa  = b_r;
    fh_wd  = total_r;
    rh_wd  = total_r;
    if (st_r == S_CLRH) begin
      fh_we = 1'b1;
      rh_we = 1'b1;
      fh_wa = cnt_r[NA-1:0];
      rh_wa = cnt_r[NA-1:0];
      fh_wd = LIST_END;
      rh_wd = LIST_END;
    end else if (st_r == S_LOAD) begin
      fh_we = 1'b1;
      rh_we = 1'b1;
    end
    if (st_r == S_IDLE) begin
      fh_ra = in_am1[NA-1:0];
      rh_ra = in_bm1[NA-1:0];
    end else if (st_r == S_WV) begin
      fh_ra = v_r;
      rh_ra = v_r;
    end else begin
      fh_ra = s_r;
      rh_ra = s_r;
    end
    ed_we = (st_r == S_LOAD);

    vis_we = 1'b0;
    vis_wa = s_r;
    vis_wd = 1'b1;
    unique case (st_r)
      S_CLRV: begin
        vis_we = 1'b1;
        vis_wa = cnt_r[NA-1:0];
        vis_wd = 1'b0;
      end
      S_WSC:   vis_we = !vis_rd;
      S_WV: begin
        vis_we = !((NW'(v_r) >= n_eff) || vis_rd || (sp_r >= NW'(MAX_NODES)));
        vis_wa = v_r;
      end
      default: vis_we = 1'b0;
    endcase
    unique case (st_r)
      S_P1RD, S_SCAN: vis_ra = u_r[NA-1:0];
      S_P3RD:         vis_ra = root_r;
      S_WN:           vis_ra = dir_r ? src_rd : dst_rd;
      default:        vis_ra = s_r;
    endcase

    stk_we = vis_we && (st_r == S_WV);
    stk_wa = NA'(sp_r - NW'(1));
    stk_wd = top_r;
    stk_ra = NA'(sp_r - NW'(2));
  end

  scc_ram #(.W(EB), .DEPTH(MAX_NODES), .AW(NA)) u_fwd_head (
    .clk, .we(fh_we), .waddr(fh_wa), .wdata(fh_wd), .raddr(fh_ra), .rdata(fh_rd)
  );
  scc_ram #(.W(EB), .DEPTH(MAX_NODES), .AW(NA)) u_rev_head (
    .clk, .we(rh_we), .waddr(rh_wa), .wdata(rh_wd), .raddr(rh_ra), .rdata(rh_rd)
  );
  scc_ram #(.W(EB), .DEPTH(MAX_EDGES), .AW(EA)) u_fwd_next (
    .clk, .we(ed_we), .waddr(total_r[EA-1:0]), .wdata(fh_rd),
    .raddr(top_r[EA-1:0]), .rdata(fn_rd)
  );
  scc_ram #(.W(EB), .DEPTH(MAX_EDGES), .AW(EA)) u_rev_next (
    .clk, .we(ed_we), .waddr(total_r[EA-1:0]), .wdata(rh_rd),
    .raddr(top_r[EA-1:0]), .rdata(rn_rd)
  );
  scc_ram #(.W(NA), .DEPTH(MAX_EDGES), .AW(EA)) u_edge_src (
    .clk, .we(ed_we), .waddr(total_r[EA-1:0]), .wdata(a_r),
    .raddr(top_r[EA-1:0]), .rdata(src_rd)
  );
  scc_ram #(.W(NA), .DEPTH(MAX_EDGES), .AW(EA)) u_edge_dst (
    .clk, .we(ed_we), .waddr(total_r[EA-1:0]), .wdata(b_r),
    .raddr(top_r[EA-1:0]), .rdata(dst_rd)
  );
  scc_ram #(.W(1), .DEPTH(MAX_NODES), .AW(NA)) u_visited (
    .clk, .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd)
  );
  scc_ram #(.W(EB), .DEPTH(MAX_NODES), .AW(NA)) u_stack (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
  );

  // Sequencer.
  always_comb begin
    st_nxt    = st_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    u_nxt     = u_r;
    sp_nxt    = sp_r;
    top_nxt   = top_r;
    total_nxt = total_r;
    drop_nxt  = drop_r;
    dir_nxt   = dir_r;
    s_nxt     = s_r;
    v_nxt     = v_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    root_nxt  = root_r;
    miss_nxt  = miss_r;
    rsc_nxt   = rsc_r;
    rfrom_nxt = rfrom_r;
    rto_nxt   = rto_r;
    unique case (st_r)
      S_CLRH: begin
        if (cnt_r == NW'(MAX_NODES - 1)) begin
          st_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            ph_nxt  = P_FIRST;
            cnt_nxt = '0;
            st_nxt  = S_CLRV;
          end else if (bad_edge) begin
            drop_nxt = 1'b1;
          end else begin
            a_nxt  = in_am1[NA-1:0];
            b_nxt  = in_bm1[NA-1:0];
            st_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        total_nxt = total_r + EB'(1);
        st_nxt    = S_IDLE;
      end
      S_CLRV: begin
        if (cnt_r + NW'(1) == n_eff) begin
          unique case (ph_r)
            P_FIRST: begin
              u_nxt  = '0;
              st_nxt = S_P1RD;
            end
            P_REV: begin
              s_nxt   = root_r;
              dir_nxt = 1'b1;
              st_nxt  = S_WS;
            end
            default: begin
              s_nxt   = miss_r;
              dir_nxt = 1'b0;
              st_nxt  = S_WS;
            end
          endcase
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      S_P1RD: st_nxt = S_P1CK;
      S_P1CK: begin
        if (!vis_rd) begin
          root_nxt = u_r[NA-1:0];
          s_nxt    = u_r[NA-1:0];
          dir_nxt  = 1'b0;
          st_nxt   = S_WS;
        end else begin
          st_nxt = S_P1NX;
        end
      end
      S_P1NX: begin
        if (u_r + NW'(1) == n_eff) begin
          ph_nxt  = P_REV;
          cnt_nxt = '0;
          st_nxt  = S_CLRV;
        end else begin
          u_nxt  = u_r + NW'(1);
          st_nxt = S_P1RD;
        end
      end
      S_SCAN: st_nxt = S_SCK;
      S_SCK: begin
        if (!vis_rd) begin
          miss_nxt = u_r[NA-1:0];
          ph_nxt   = P_BACK;
          cnt_nxt  = '0;
          st_nxt   = S_CLRV;
        end else if (u_r + NW'(1) == n_eff) begin
          rsc_nxt   = 1'b1;
          rfrom_nxt = '0;
          rto_nxt   = '0;
          st_nxt    = S_OUT;
        end else begin
          u_nxt  = u_r + NW'(1);
          st_nxt = S_SCAN;
        end
      end
      S_P3RD: st_nxt = S_P3CK;
      S_P3CK: begin
        rsc_nxt = 1'b0;
        if (!vis_rd) begin
          rfrom_nxt = NODE_FIELD_W'(CW'(miss_r) + CW'(1));
          rto_nxt   = NODE_FIELD_W'(CW'(root_r) + CW'(1));
        end else begin
          rfrom_nxt = NODE_FIELD_W'(CW'(root_r) + CW'(1));
          rto_nxt   = NODE_FIELD_W'(CW'(miss_r) + CW'(1));
        end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_tvalid) begin
          total_nxt = '0;
          drop_nxt  = 1'b0;
          cnt_nxt   = '0;
          st_nxt    = S_CLRH;
        end
      end
      S_WS:  st_nxt = S_WSC;
      S_WSC: begin
        if (vis_rd) begin
          st_nxt = done_st;
          u_nxt  = (ph_r == P_REV) ? '0 : u_r;
        end else begin
          sp_nxt = '0;
          st_nxt = S_WH;
        end
      end
      S_WH: begin
        top_nxt = dir_r ? rh_rd : fh_rd;
        sp_nxt  = sp_r + NW'(1);
        st_nxt  = S_WE;
      end
      S_WE: begin
        if (top_r == LIST_END) begin
          if (sp_r == NW'(1)) begin
            st_nxt = done_st;
            u_nxt  = (ph_r == P_REV) ? '0 : u_r;
          end else begin
            sp_nxt = sp_r - NW'(1);
            st_nxt = S_WP;
          end
        end else begin
          st_nxt = S_WN;
        end
      end
      S_WP: begin
        top_nxt = stk_rd;
        st_nxt  = S_WE;
      end
      S_WN: begin
        top_nxt = dir_r ? rn_rd : fn_rd;
        v_nxt   = dir_r ? src_rd : dst_rd;
        st_nxt  = S_WV;
      end
      S_WV: begin
        st_nxt = stk_we ? S_WH : S_WE;
      end
      default: st_nxt = S_CLRH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLRH;
      ph_r    <= P_FIRST;
      cnt_r   <= '0;
      u_r     <= '0;
      sp_r    <= '0;
      total_r <= '0;
      drop_r  <= 1'b0;
      root_r  <= '0;
      ncfg_r  <= NODE_FIELD_W'(1);
      out_tvalid <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      u_r     <= u_nxt;
      sp_r    <= sp_nxt;
      total_r <= total_nxt;
      drop_r  <= drop_nxt;
      root_r  <= root_nxt;
      if (cfg_valid && cfg_ready) begin
        ncfg_r <= cfg_data;
      end
      if (st_r == S_OUT && !out_tvalid) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r   <= top_nxt;
    dir_r   <= dir_nxt;
    s_r     <= s_nxt;
    v_r     <= v_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    miss_r  <= miss_nxt;
    rsc_r   <= rsc_nxt;
    rfrom_r <= rfrom_nxt;
    rto_r   <= rto_nxt;
    if (st_r == S_OUT && !out_tvalid) begin
      ov_r <= drop_r;
      od_r <= {drop_r, rto_r, rfrom_r, rsc_r};
    end
  end

  assign out_tdata = {ov_r, od_r[OUT_DATA_W-2:0]};

  // The walk stack never grows beyond one entry per node.
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= NW'(MAX_NODES))
    else $error("walk stack depth out of range");

  // The edge count never passes the store capacity.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= EB'(MAX_EDGES))
    else $error("edge count beyond capacity");

  // An edge is linked only right after it was accepted.
  a_load_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_LOAD |-> $past(in_acc) && !$past(in_tuser))
    else $error("edge linked without an accepted item");

  // A result appears only when the sequencer hands one over.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st_r) == S_OUT)
    else $error("result raised outside the output step");

endmodule

// File: tb/sv/scc_checker.sv
// ----------------------------------------------------------------------------
// scc_checker: result predictor and comparator for the connectivity check
// Watches the configuration, input and result channels, keeps its own copy of
// the edge lists, predicts each result and compares it with the unit's output.
// ----------------------------------------------------------------------------
module scc_checker
  import scc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [NODE_FIELD_W-1:0] cfg_data,
  input  logic                    in_tvalid,
  input  logic                    in_tready,
  input  logic [IN_DATA_W-1:0]    in_tdata,   // [10:0] edge_from, [21:11] edge_to
  input  logic                    in_tuser,   // [0] req_type
  input  logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [OUT_DATA_W-1:0]   out_tdata,  // [0] strongly_connected, [11:1] route_from,
                                              // [22:12] route_to, [23] edge_overflow
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NIL = SCC_MAX_EDGES;

  typedef struct packed {
    logic                    connected;
    logic [NODE_FIELD_W-1:0] route_from;
    logic [NODE_FIELD_W-1:0] route_to;
    logic                    overflow;
  } verdict_t;

  verdict_t                verdicts[$];
  logic [NODE_FIELD_W-1:0] node_cnt;
  int  fwd_head[SCC_MAX_NODES];
  int  rev_head[SCC_MAX_NODES];
  int  e_src[SCC_MAX_EDGES];
  int  e_dst[SCC_MAX_EDGES];
  int  fwd_nxt[SCC_MAX_EDGES];
  int  rev_nxt[SCC_MAX_EDGES];
  int  n_edges;
  bit  dropped;
  bit  seen[SCC_MAX_NODES];
  int  stk_node[SCC_MAX_NODES];
  int  stk_cur[SCC_MAX_NODES];
  int  root;

  function automatic void clear_lists();
    for (int i = 0; i < SCC_MAX_NODES; i++) begin
      fwd_head[i] = NIL;
      rev_head[i] = NIL;
    end
    n_edges = 0;
    dropped = 0;
  endfunction

  function automatic void clear_seen();
    for (int i = 0; i < SCC_MAX_NODES; i++) seen[i] = 0;
  endfunction

  function automatic int live_nodes();
    if (node_cnt == 0) return 1;
    if (node_cnt > SCC_MAX_NODES) return SCC_MAX_NODES;
    return int'(node_cnt);
  endfunction

  // Iterative depth-first walk; rev selects the reversed edge lists.
  function automatic void dfs(int start, bit rev, int n);
    int sp;
    int e;
    int v;
    if (start >= n || seen[start]) return;
    seen[start] = 1;
    stk_node[0] = start;
    stk_cur[0]  = rev ? rev_head[start] : fwd_head[start];
    sp = 1;
    while (sp > 0) begin
      e = stk_cur[sp-1];
      if (e >= NIL) begin
        sp--;
        continue;
      end
      stk_cur[sp-1] = rev ? rev_nxt[e] : fwd_nxt[e];
      v = rev ? e_src[e] : e_dst[e];
      if (v >= n || seen[v] || sp >= SCC_MAX_NODES) continue;
      seen[v] = 1;
      stk_node[sp] = v;
      stk_cur[sp]  = rev ? rev_head[v] : fwd_head[v];
      sp++;
    end
  endfunction

  function automatic void add_edge(int a, int b);
    int n;
    n = live_nodes();
    if (a == 0 || a > n || b == 0 || b > n || n_edges >= SCC_MAX_EDGES) begin
      dropped = 1;
      return;
    end
    a--;
    b--;
    e_src[n_edges]   = a;
    e_dst[n_edges]   = b;
    fwd_nxt[n_edges] = fwd_head[a];
    fwd_head[a]      = n_edges;
    rev_nxt[n_edges] = rev_head[b];
    rev_head[b]      = n_edges;
    n_edges++;
  endfunction

  function automatic verdict_t check_graph();
    verdict_t r;
    int n;
    int missing;
    n = live_nodes();
    clear_seen();
    for (int u = 0; u < n; u++) begin
      if (!seen[u]) begin
        root = u;
        dfs(u, 0, n);
      end
    end
    clear_seen();
    dfs(root, 1, n);
    missing = n;
    for (int u = 0; u < n; u++) begin
      if (!seen[u]) begin
        missing = u;
        break;
      end
    end
    r.overflow = dropped;
    if (missing >= n) begin
      r.connected  = 1;
      r.route_from = '0;
      r.route_to   = '0;
    end else begin
      r.connected = 0;
      clear_seen();
      dfs(missing, 0, n);
      if (!seen[root]) begin
        r.route_from = NODE_FIELD_W'(missing + 1);
        r.route_to   = NODE_FIELD_W'(root + 1);
      end else begin
        r.route_from = NODE_FIELD_W'(root + 1);
        r.route_to   = NODE_FIELD_W'(missing + 1);
      end
    end
    clear_lists();
    return r;
  endfunction

  initial begin
    errors   = 0;
    node_cnt = 1;
    root     = 0;
    clear_lists();
    clear_seen();
  end

  assign pending = verdicts.size();

  always @(posedge clk) begin
    verdict_t exp_v;
    verdict_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) node_cnt = cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == 1'b0) add_edge(int'(in_tdata[10:0]), int'(in_tdata[21:11]));
        else verdicts = {verdicts, check_graph()};
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[0], out_tdata[11:1], out_tdata[22:12], out_tdata[23]};
        if (verdicts.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, out_tdata);
          errors++;
        end else begin
          exp_v = verdicts.pop_front();
          if (got.connected !== exp_v.connected) begin
            $display("%0t: strongly_connected expected %0d actual %0d",
                     $time, exp_v.connected, got.connected);
            errors++;
          end
          if (got.route_from !== exp_v.route_from) begin
            $display("%0t: route_from expected %0d actual %0d",
                     $time, exp_v.route_from, got.route_from);
            errors++;
          end
          if (got.route_to !== exp_v.route_to) begin
            $display("%0t: route_to expected %0d actual %0d",
                     $time, exp_v.route_to, got.route_to);
            errors++;
          end
          if (got.overflow !== exp_v.overflow) begin
            $display("%0t: edge_overflow expected %0d actual %0d",
                     $time, exp_v.overflow, got.overflow);
            errors++;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the strong connectivity check unit
// Loads directed graphs of many sizes, runs the check on each and lets the
// checker compare every result; the receiver stalls at random throughout.
// ----------------------------------------------------------------------------
module tb_top;
  import scc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Request kinds carried in in_tuser.
  localparam logic REQ_EDGE   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;
  // Cycles to let pass after the last result before touching the register.
  // This covers the clearing pass of the edge lists after each result.
  localparam int SETTLE_CYCLES = 1200;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [NODE_FIELD_W-1:0] cfg_data = '0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata = '0;    // [10:0] edge_from, [21:11] edge_to
  logic                    in_tuser = 1'b0;  // [0] req_type
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;        // [0] strongly_connected, [11:1] route_from,
                                             // [22:12] route_to, [23] edge_overflow
  int errors;
  int pending;
  int items_sent = 0;
  bit long_hold_req = 0;

  always #6 clk = ~clk;

  strong_connectivity_check_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  scc_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  // Mostly short gaps, now and then a long one, and often none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item on the input channel and wait until the unit takes it.
  // The valid line stays high between back-to-back items.
  task automatic send_item(logic kind, logic [10:0] src, logic [10:0] dst);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, dst, src};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_edge(int src, int dst);
    send_item(REQ_EDGE, 11'(src), 11'(dst));
  endtask

  // The edge fields are ignored on a finish item, so they carry random noise.
  task automatic send_finish();
    send_item(REQ_FINISH, 11'($urandom), 11'($urandom));
  endtask

  // Drop valid, wait for every outstanding result, then let the unit settle.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(int value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= 11'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request while the sender
  // keeps offering finish items, so that the result register backs up.
  initial begin
    int hold;
    int r;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_tready <= 1'b0;
        hold = 0;
        while (hold < 3000) begin
          @(negedge clk);
          hold++;
        end
        long_hold_req = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_tready <= 1'b1;
        end else if (r < 97) begin
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b0;
          repeat ($urandom_range(20, 120)) @(negedge clk);
        end
      end
    end
  end

  // One random graph on n nodes. For n up to 16, often a ring through all nodes in
  // random order, at times missing an edge, is laid first so connected graphs come up.
  task automatic random_graph(int n);
    int k;
    int order[$];
    int j;
    int t;
    if (n <= 16 && $urandom_range(0, 1)) begin
      order = {};
      for (int i = 1; i <= n; i++) order = {order, i};
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) != 0) send_edge(order[i], order[(i + 1) % n]);
      end
    end
    k = (n > 16) ? $urandom_range(0, 40) : $urandom_range(0, 2 * n + 2);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_edge($urandom_range(0, 2047), $urandom_range(0, 2047));
      end else begin
        send_edge($urandom_range(1, n), $urandom_range(1, n));
      end
    end
    send_finish();
  endtask

  // Stimulus.
  initial begin
    int n;
    int cnt;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Node count zero behaves as a single node.
    write_node_count(0);
    send_finish();
    // A three-node ring, then a chain.
    write_node_count(3);
    send_edge(1, 2);
    send_edge(2, 3);
    send_edge(3, 1);
    send_finish();
    send_edge(1, 2);
    send_edge(2, 3);
    send_finish();
    // Endpoints of zero, above the node count and at the field maximum.
    send_edge(0, 1);
    send_edge(1, 4);
    send_edge(2047, 2);
    send_edge(3, 2047);
    send_finish();
    // A count above the capacity acts as the capacity; use the top node.
    write_node_count(2047);
    send_edge(1024, 1);
    send_edge(1, 1024);
    send_finish();
    // Lower the count after loading: edges to dropped nodes are ignored.
    write_node_count(4);
    send_edge(1, 2);
    send_edge(2, 1);
    send_edge(2, 3);
    send_edge(3, 4);
    send_edge(4, 2);
    write_node_count(2);
    send_finish();

    // The edge store fills up: the extra edges are dropped and flagged.
    write_node_count(3);
    for (int i = 0; i < SCC_MAX_EDGES + 4; i++) begin
      send_edge($urandom_range(1, 3), $urandom_range(1, 3));
    end
    send_finish();

    // Back-pressure: a burst of small graphs while the receiver holds off.
    write_node_count(2);
    long_hold_req = 1;
    for (int i = 0; i < 6; i++) begin
      send_edge(1, 2);
      send_finish();
    end

    // Random phases until enough items have gone in beside the fill test.
    cnt = 0;
    while (cnt < 700) begin
      case ($urandom_range(0, 19))
        0:       n = 1024;
        1:       n = $urandom_range(1025, 2047);
        2:       n = 0;
        3:       n = $urandom_range(17, 200);
        default: n = $urandom_range(1, 12);
      endcase
      write_node_count(n);
      if (n == 0) n = 1;
      if (n > 1024) n = 1024;
      for (int g = (n > 16) ? 1 : $urandom_range(1, 6); g > 0; g--) begin
        t_start_count: begin
          int before_cnt;
          before_cnt = items_sent;
          random_graph(n);
          cnt += items_sent - before_cnt;
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
